// ===== src/assert_macros.svh =====
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define CHK_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("check failed: same-cycle rule");

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("check failed: next-cycle rule");

`endif

// ===== src/mhsi_pkg.sv =====
// Package: widths, codes and lane control types of the magnetometer calibration block.
`default_nettype none
package mhsi_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int SCALE_FRAC_BITS = 12;
    localparam int GAIN_BITS       = 16;
    localparam int NUM_AXES        = 3;

    localparam int SUM_BITS = SAMPLE_BITS + 2;
    localparam int DEN_BITS = SAMPLE_BITS + 3;
    localparam int NUM_BITS = SUM_BITS + SCALE_FRAC_BITS + 2;
    localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS + 2;

    localparam int SMAX_I = 2 ** (SAMPLE_BITS - 1) - 1;
    localparam int SMIN_I = -(2 ** (SAMPLE_BITS - 1));
    localparam int ONE_I  = 2 ** SCALE_FRAC_BITS;
    localparam int GMAX_I = 2 ** GAIN_BITS - 1;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = SAMPLE_BITS'(SMAX_I);
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = SAMPLE_BITS'(SMIN_I);
    localparam logic [GAIN_BITS-1:0] SCALE_ONE =
        GAIN_BITS'((ONE_I > GMAX_I) ? GMAX_I : ONE_I);

    localparam logic [1:0] CMD_START   = 2'd0;
    localparam logic [1:0] CMD_SAMPLE  = 2'd1;
    localparam logic [1:0] CMD_FINISH  = 2'd2;
    localparam logic [1:0] CMD_CORRECT = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_SAMPLES = 2'd1;
    localparam logic [1:0] ST_SATURATED  = 2'd2;

    typedef struct packed {
        logic clear;
        logic track;
        logic fin;
        logic div_start;
        logic mul;
        logic corr;
    } t_lane_ctrl;

    typedef struct packed {
        logic busy;
        logic sat;
    } t_lane_stat;

endpackage
`default_nettype wire

// ===== src/mhsi_ifs.sv =====
// Channel interfaces: sample/command input and result output.
`default_nettype none
interface mhsi_in_if import mhsi_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic [1:0]                    cmd;
    logic signed [SAMPLE_BITS-1:0] mag_x;
    logic signed [SAMPLE_BITS-1:0] mag_y;
    logic signed [SAMPLE_BITS-1:0] mag_z;

    modport source (output valid, output cmd, output mag_x, output mag_y, output mag_z,
                    input ready);
    modport sink   (input valid, input cmd, input mag_x, input mag_y, input mag_z,
                    output ready);
endinterface

interface mhsi_out_if import mhsi_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] cor_x;
    logic signed [SAMPLE_BITS-1:0] cor_y;
    logic signed [SAMPLE_BITS-1:0] cor_z;
    logic signed [SAMPLE_BITS-1:0] off_x;
    logic signed [SAMPLE_BITS-1:0] off_y;
    logic signed [SAMPLE_BITS-1:0] off_z;
    logic [GAIN_BITS-1:0]          gain_x;
    logic [GAIN_BITS-1:0]          gain_y;
    logic [GAIN_BITS-1:0]          gain_z;
    logic [1:0]                    status;

    modport source (output valid, output cor_x, output cor_y, output cor_z,
                    output off_x, output off_y, output off_z,
                    output gain_x, output gain_y, output gain_z, output status,
                    input ready);
    modport sink   (input valid, input cor_x, input cor_y, input cor_z,
                    input off_x, input off_y, input off_z,
                    input gain_x, input gain_y, input gain_z, input status,
                    output ready);
endinterface
`default_nettype wire

// ===== src/mhsi_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module mhsi_div import mhsi_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [NUM_BITS-1:0] i_num,
    input  wire logic [DEN_BITS-1:0] i_den,
    output logic                     o_busy,
    output logic                     o_done,
    output logic [NUM_BITS-1:0]      o_quo
);
    localparam int CW = $clog2(NUM_BITS + 1);

    logic [DEN_BITS-1:0] r_rem, r_den;
    logic [NUM_BITS-1:0] r_quo;
    logic [CW-1:0]       r_cnt;
    logic                r_busy, r_done;

    logic [DEN_BITS:0]   trial;
    logic                fits;

    assign trial = {r_rem, r_quo[NUM_BITS-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= i_num;
        end else if (r_busy) begin
            // remainder stays below the divisor, so DEN_BITS hold it
            r_rem <= fits ? DEN_BITS'(trial - {1'b0, r_den}) : trial[DEN_BITS-1:0];
            r_quo <= {r_quo[NUM_BITS-2:0], fits};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule
`default_nettype wire

// ===== src/mhsi_lane.sv =====
// One axis lane: min/max tracking, offset and scale update, sample correction.
`default_nettype none
module mhsi_lane import mhsi_pkg::*; (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_lane_ctrl                    i_ctrl,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic [SUM_BITS-1:0]           i_sum,
    output t_lane_stat                         o_stat,
    output logic signed [SAMPLE_BITS-1:0]      o_cor,
    output logic signed [SAMPLE_BITS-1:0]      o_off,
    output logic [GAIN_BITS-1:0]               o_gain,
    output logic [SAMPLE_BITS-1:0]             o_range
);
    localparam int VW = PROD_BITS + 1 - SCALE_FRAC_BITS;
    localparam logic signed [VW-1:0] VMAX = VW'(SMAX_I);
    localparam logic signed [VW-1:0] VMIN = VW'(SMIN_I);
    localparam logic signed [PROD_BITS:0] HALF_LSB =
        (PROD_BITS + 1)'(2 ** (SCALE_FRAC_BITS - 1));

    logic signed [SAMPLE_BITS-1:0] r_min, r_max, r_off, r_cor;
    logic [GAIN_BITS-1:0]          r_gain;
    logic [SAMPLE_BITS-1:0]        r_range;
    logic signed [PROD_BITS-1:0]   r_prod;
    logic                          r_sat;

    logic signed [SAMPLE_BITS:0]   mm_sum, mm_diff, s_diff;
    logic signed [GAIN_BITS:0]     gain_s;
    logic signed [PROD_BITS:0]     rounded;
    logic signed [VW-1:0]          v;
    logic [SAMPLE_BITS+1:0]        r3;
    logic [NUM_BITS-1:0]           num;
    logic [DEN_BITS-1:0]           den;
    logic                          div_busy, div_done;
    logic [NUM_BITS-1:0]           quo;

    assign mm_sum  = {r_max[SAMPLE_BITS-1], r_max} + {r_min[SAMPLE_BITS-1], r_min};
    assign mm_diff = {r_max[SAMPLE_BITS-1], r_max} - {r_min[SAMPLE_BITS-1], r_min};
    assign s_diff  = {i_sample[SAMPLE_BITS-1], i_sample} - {r_off[SAMPLE_BITS-1], r_off};
    assign gain_s  = {1'b0, r_gain};

    assign rounded = {r_prod[PROD_BITS-1], r_prod} + HALF_LSB;
    assign v       = rounded[PROD_BITS:SCALE_FRAC_BITS];

    // numerator sum*2^(F+1) + 3r over divisor 6r gives the rounded ratio
    assign r3  = {2'b00, r_range} + {1'b0, r_range, 1'b0};
    assign num = NUM_BITS'({i_sum, {(SCALE_FRAC_BITS + 1){1'b0}}}) + NUM_BITS'(r3);
    assign den = {r3, 1'b0};

    mhsi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctrl.div_start && (r_range != '0)),
        .i_num   (num),
        .i_den   (den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min  <= SAMPLE_MAX;
            r_max  <= SAMPLE_MIN;
            r_off  <= '0;
            r_gain <= SCALE_ONE;
        end else begin
            if (i_ctrl.clear) begin
                r_min <= SAMPLE_MAX;
                r_max <= SAMPLE_MIN;
            end else if (i_ctrl.track) begin
                if (i_sample < r_min) r_min <= i_sample;
                if (i_sample > r_max) r_max <= i_sample;
            end
            if (i_ctrl.fin) begin
                r_off <= mm_sum[SAMPLE_BITS:1];
            end
            if (div_done) begin
                r_gain <= (|quo[NUM_BITS-1:GAIN_BITS]) ? '1 : quo[GAIN_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.fin) begin
            r_range <= mm_diff[SAMPLE_BITS-1:0];
        end
        if (i_ctrl.mul) begin
            r_prod <= s_diff * gain_s;
        end
        if (i_ctrl.corr) begin
            // clamp to the sample range and flag
            if (v > VMAX) begin
                r_cor <= SAMPLE_MAX;
                r_sat <= 1'b1;
            end else if (v < VMIN) begin
                r_cor <= SAMPLE_MIN;
                r_sat <= 1'b1;
            end else begin
                r_cor <= v[SAMPLE_BITS-1:0];
                r_sat <= 1'b0;
            end
        end
    end

    assign o_stat.busy = div_busy || div_done;
    assign o_stat.sat  = r_sat;
    assign o_cor       = r_cor;
    assign o_off       = r_off;
    assign o_gain      = r_gain;
    assign o_range     = r_range;
endmodule
`default_nettype wire

// ===== src/magnetometer_hard_soft_iron_calibration.sv =====
// Top level: command sequencer, three axis lanes, range/status merge and output register.
//
//  channel  | dir | beat contents
//  ---------+-----+-------------------------------------------------------------
//  i_in     | in  | cmd, mag_x, mag_y, mag_z
//  o_out    | out | cor_x/y/z, off_x/y/z, gain_x/y/z, status (one beat per input)
//
//  Start and calibration sample pass from accept through the run state to the done
//  state, which loads the output register. Correct sample multiplies in the run state
//  and rounds and clamps in the correct state. Finish, once samples are in, steps through
//  the range sum, the divider start and the bit-serial divider in each lane. One command
//  is in flight at a time; the next is accepted once the result sits in the output
//  register. Reset (synchronous, active low) restores unity scales, zero offsets and
//  empty trackers. A stalled output holds its beat and the sequencer waits in its done state.
`default_nettype none
module magnetometer_hard_soft_iron_calibration import mhsi_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mhsi_in_if.sink     i_in,
    mhsi_out_if.source  o_out
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RUN    = 3'd1;
    localparam logic [2:0] S_SUM    = 3'd2;
    localparam logic [2:0] S_DSTART = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_CORR   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] r_state, n_state;
    logic [1:0] r_cmd, r_status, n_status;
    logic       r_any, n_any;
    logic [SUM_BITS-1:0] r_sum;
    logic signed [SAMPLE_BITS-1:0] r_s [NUM_AXES];

    t_lane_ctrl ctrl;
    t_lane_stat stat [NUM_AXES];
    logic signed [SAMPLE_BITS-1:0] cor [NUM_AXES];
    logic signed [SAMPLE_BITS-1:0] off [NUM_AXES];
    logic [GAIN_BITS-1:0]          gain [NUM_AXES];
    logic [SAMPLE_BITS-1:0]        rng [NUM_AXES];

    logic r_ov;
    logic signed [SAMPLE_BITS-1:0] r_ocor [NUM_AXES];
    logic signed [SAMPLE_BITS-1:0] r_ooff [NUM_AXES];
    logic [GAIN_BITS-1:0]          r_ogain [NUM_AXES];
    logic [1:0]                    r_ostat;

    logic accept, load, any_busy, any_sat;

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    // in the done state, load the output register when it is empty or its beat leaves now
    assign load       = (r_state == S_DONE) && (!r_ov || o_out.ready);

    assign any_busy = stat[0].busy || stat[1].busy || stat[2].busy;
    assign any_sat  = stat[0].sat || stat[1].sat || stat[2].sat;

    // lane control decode
    always_comb begin
        ctrl = '0;
        if (r_state == S_RUN) begin
            unique case (r_cmd)
                CMD_START:   ctrl.clear = 1'b1;
                CMD_SAMPLE:  ctrl.track = 1'b1;
                CMD_FINISH:  ctrl.fin   = r_any;
                CMD_CORRECT: ctrl.mul   = 1'b1;
                default:     ctrl = '0;
            endcase
        end
        ctrl.div_start = (r_state == S_DSTART);
        ctrl.corr      = (r_state == S_CORR);
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        n_any    = r_any;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_RUN;
            end
            S_RUN: begin
                n_status = ST_OK;
                unique case (r_cmd)
                    CMD_START: begin
                        n_any   = 1'b0;
                        n_state = S_DONE;
                    end
                    CMD_SAMPLE: begin
                        n_any   = 1'b1;
                        n_state = S_DONE;
                    end
                    CMD_FINISH: begin
                        if (r_any) begin
                            n_state = S_SUM;
                        end else begin
                            n_status = ST_NO_SAMPLES;
                            n_state  = S_DONE;
                        end
                    end
                    default: n_state = S_CORR;
                endcase
            end
            S_SUM:    n_state = S_DSTART;
            S_DSTART: n_state = S_DIV;
            S_DIV: begin
                if (!any_busy) n_state = S_DONE;
            end
            S_CORR: n_state = S_DONE;
            S_DONE: begin
                if (load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        // the clamp flags are registered in S_CORR and read in S_DONE
        if (r_state == S_DONE && r_cmd == CMD_CORRECT && any_sat) begin
            n_status = ST_SATURATED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_any    <= 1'b0;
            r_status <= ST_OK;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_any    <= n_any;
            r_status <= n_status;
            if (load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // input capture, range sum and output payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_in.cmd;
            r_s[0] <= i_in.mag_x;
            r_s[1] <= i_in.mag_y;
            r_s[2] <= i_in.mag_z;
        end
        if (r_state == S_SUM) begin
            r_sum <= SUM_BITS'(rng[0]) + SUM_BITS'(rng[1]) + SUM_BITS'(rng[2]);
        end
        if (load) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_ocor[a]  <= (r_cmd == CMD_CORRECT) ? cor[a] : '0;
                r_ooff[a]  <= off[a];
                r_ogain[a] <= gain[a];
            end
            r_ostat <= (r_cmd == CMD_CORRECT && any_sat) ? ST_SATURATED : r_status;
        end
    end

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
        mhsi_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (ctrl),
            .i_sample (r_s[g]),
            .i_sum    (r_sum),
            .o_stat   (stat[g]),
            .o_cor    (cor[g]),
            .o_off    (off[g]),
            .o_gain   (gain[g]),
            .o_range  (rng[g])
        );
    end

    assign o_out.valid  = r_ov;
    assign o_out.cor_x  = r_ocor[0];
    assign o_out.cor_y  = r_ocor[1];
    assign o_out.cor_z  = r_ocor[2];
    assign o_out.off_x  = r_ooff[0];
    assign o_out.off_y  = r_ooff[1];
    assign o_out.off_z  = r_ooff[2];
    assign o_out.gain_x = r_ogain[0];
    assign o_out.gain_y = r_ogain[1];
    assign o_out.gain_z = r_ogain[2];
    assign o_out.status = r_ostat;
endmodule
`default_nettype wire

// ===== src/mhsi_checker.sv =====
// Port-level checker for the calibration block, with its bind.
`default_nettype none
`include "assert_macros.svh"
module mhsi_checker import mhsi_pkg::*; (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic signed [SAMPLE_BITS-1:0] i_cor_x,
    input wire logic signed [SAMPLE_BITS-1:0] i_cor_y,
    input wire logic signed [SAMPLE_BITS-1:0] i_cor_z,
    input wire logic [GAIN_BITS-1:0]          i_gain_x,
    input wire logic [GAIN_BITS-1:0]          i_gain_y,
    input wire logic [GAIN_BITS-1:0]          i_gain_z,
    input wire logic [1:0]                    i_status
);
    // hold a stalled beat
    `CHK_NEXT(a_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_cor_x) && $stable(i_cor_y) && $stable(i_cor_z) && $stable(i_status))
    // a finish without samples carries no correction
    `CHK_IMPL(a_nosamp_zero, i_out_valid && i_status == ST_NO_SAMPLES, i_cor_x == 0 && i_cor_y == 0 && i_cor_z == 0)
    // a saturated flag means some axis sits at a rail
    `CHK_IMPL(a_sat_rail, i_out_valid && i_status == ST_SATURATED, i_cor_x == SAMPLE_MAX || i_cor_x == SAMPLE_MIN || i_cor_y == SAMPLE_MAX || i_cor_y == SAMPLE_MIN || i_cor_z == SAMPLE_MAX || i_cor_z == SAMPLE_MIN)
    // scales never collapse to zero
    `CHK_IMPL(a_gain_nonzero, i_out_valid, i_gain_x != 0 && i_gain_y != 0 && i_gain_z != 0)
endmodule

bind magnetometer_hard_soft_iron_calibration mhsi_checker u_mhsi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_cor_x     (o_out.cor_x),
    .i_cor_y     (o_out.cor_y),
    .i_cor_z     (o_out.cor_z),
    .i_gain_x    (o_out.gain_x),
    .i_gain_y    (o_out.gain_y),
    .i_gain_z    (o_out.gain_z),
    .i_status    (o_out.status)
);
`default_nettype wire
